/* src/dic_pkg.sv */
// Shared types and constants of the DER INTEGER content decoder.
package dic_pkg;

  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_BYTES  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 4'd1;

  localparam logic [2:0] WORD_BYTES_RST  = 3'd4;
  localparam logic       SIGNED_MODE_RST = 1'b1;
  localparam logic [BYTE_W-1:0] FILL_BYTE = 8'hFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_CORRUPT   = 2'd2
  } status_t;

  typedef struct packed {
    logic [VALUE_W-1:0] decoded_value;
    logic               nonnegative;
    status_t            status;
  } result_t;

endpackage

/* src/dic_core.sv */
// Per-integer accumulation state and end-of-integer result logic.
module dic_core import dic_pkg::*; #(
  parameter int MAX_WORD_BYTES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [BYTE_W-1:0] content_byte,
  input  logic              last_byte,
  input  logic [2:0]        word_bytes,
  input  logic              signed_mode,
  output result_t           res
);

  localparam int ACC_W = MAX_WORD_BYTES * BYTE_W;
  localparam int CNT_W = $clog2(MAX_WORD_BYTES + 1);
  localparam int CMP_W = 4;

  logic [ACC_W-1:0] accumulator, accumulator_next;
  logic [CNT_W-1:0] kept_byte_count, kept_byte_count_next;
  logic             at_first_byte, at_first_byte_next;
  logic             negative_value, negative_value_next;
  logic             length_overflow, length_overflow_next;

  logic [CNT_W-1:0] eff_bytes;
  logic             keep;
  logic [ACC_W-1:0] word;
  logic             top_bit;
  status_t          status;
  logic [VALUE_W-1:0] value_out;

  // Clamp the word size into 2..MAX_WORD_BYTES
  always_comb begin
    if ({1'b0, word_bytes} < CMP_W'(2)) begin
      eff_bytes = CNT_W'(2);
    end else if ({1'b0, word_bytes} > CMP_W'(MAX_WORD_BYTES)) begin
      eff_bytes = CNT_W'(MAX_WORD_BYTES);
    end else begin
      eff_bytes = CNT_W'(word_bytes);
    end
  end

  always_comb begin
    accumulator_next     = accumulator;
    kept_byte_count_next = kept_byte_count;
    length_overflow_next = length_overflow;
    negative_value_next  = at_first_byte ? content_byte[BYTE_W-1] : negative_value;
    at_first_byte_next   = 1'b0;
    // drop a leading zero octet
    keep = !(at_first_byte && (content_byte == '0));
    if (keep && !length_overflow) begin
      if (kept_byte_count >= eff_bytes) begin
        length_overflow_next = 1'b1;
      end else begin
        accumulator_next     = {accumulator[ACC_W-BYTE_W-1:0], content_byte};
        kept_byte_count_next = kept_byte_count + CNT_W'(1);
      end
    end
  end

  // Build the word: kept bytes, sign fill up to the word size, zero above
  always_comb begin
    word    = '0;
    top_bit = 1'b0;
    for (int i = 0; i < MAX_WORD_BYTES; i++) begin
      if (CNT_W'(i) < eff_bytes) begin
        if (CNT_W'(i) < kept_byte_count_next) begin
          word[i*BYTE_W +: BYTE_W] = accumulator_next[i*BYTE_W +: BYTE_W];
        end else if (negative_value_next) begin
          word[i*BYTE_W +: BYTE_W] = FILL_BYTE;
        end
      end
      if (CNT_W'(i) == eff_bytes - CNT_W'(1)) begin
        top_bit = word[i*BYTE_W + BYTE_W - 1];
      end
    end
  end

  always_comb begin
    status = ST_OK;
    if (length_overflow_next) begin
      status = ST_TOO_LARGE;
    end else if (signed_mode) begin
      if (!negative_value_next && top_bit) status = ST_TOO_LARGE;
    end else if (negative_value_next) begin
      status = ST_CORRUPT;
    end
  end

  generate
    if (ACC_W >= VALUE_W) begin : g_trunc
      assign value_out = word[VALUE_W-1:0];
    end else begin : g_ext
      assign value_out = {{(VALUE_W-ACC_W){1'b0}}, word};
    end
  endgenerate

  assign res.decoded_value = (status == ST_OK) ? value_out : '0;
  assign res.nonnegative   = !negative_value_next;
  assign res.status        = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator     <= '0;
      kept_byte_count <= '0;
      at_first_byte   <= 1'b1;
      negative_value  <= 1'b0;
      length_overflow <= 1'b0;
    end else if (step) begin
      if (last_byte) begin
        accumulator     <= '0;
        kept_byte_count <= '0;
        at_first_byte   <= 1'b1;
        negative_value  <= 1'b0;
        length_overflow <= 1'b0;
      end else begin
        accumulator     <= accumulator_next;
        kept_byte_count <= kept_byte_count_next;
        at_first_byte   <= at_first_byte_next;
        negative_value  <= negative_value_next;
        length_overflow <= length_overflow_next;
      end
    end
  end

endmodule

/* src/der_integer_content_decoder_top.sv */
// Top level of the DER INTEGER content decoder: input register, core, result register.
//
// Channel   Direction  Payload
// s_axis    in         tdata[7:0] content_byte, tlast last_byte
// m_axis    out        tdata[31:0] decoded_value, [32] nonnegative, [34:33] status
// cfg       in         cfg_index register number, cfg_data value
//
// One item per cycle sustained, unless a last octet waits on a stalled result; a
// result passes through the input register, then the result register.
// Synchronous reset clears the integer in progress and loads word_bytes 4,
// signed_mode 1. A stalled result holds the pipeline only when the item
// behind it is itself a last octet; other octets keep flowing.
module der_integer_content_decoder_top import dic_pkg::*; #(
  parameter int MAX_WORD_BYTES = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] content_byte
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // [31:0] value, [32] nonneg, [34:33] status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [2:0]        word_bytes;
  logic              signed_mode;
  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;
  logic              advance;
  result_t           core_res;
  result_t           out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      word_bytes  <= WORD_BYTES_RST;
      signed_mode <= SIGNED_MODE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WORD_BYTES:  word_bytes  <= cfg_data;
        CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A non-last octet never waits; a last one waits for a free result slot
  assign advance       = in_valid && (!in_last || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  dic_core #(
    .MAX_WORD_BYTES(MAX_WORD_BYTES)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .content_byte (in_byte),
    .last_byte    (in_last),
    .word_bytes   (word_bytes),
    .signed_mode  (signed_mode),
    .res          (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && in_last) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last) begin
      out_res <= core_res;
    end
  end

  assign m_axis_tdata = {5'b0, out_res.status, out_res.nonnegative, out_res.decoded_value};

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (out_res.status != ST_OK) |-> out_res.decoded_value == '0)
    else $error("nonzero value on error status");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (out_res.status == ST_OK || out_res.status == ST_TOO_LARGE ||
                       out_res.status == ST_CORRUPT))
    else $error("bad status code");

  a_rose_from_last: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(advance && in_last))
    else $error("result without a last octet");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    advance && in_last && m_axis_tvalid |-> m_axis_tready)
    else $error("result overwritten while stalled");

endmodule
